/* hw/rtl/ljfs_pkg.sv */
// Shared types and constants for the longest-job-first scheduler.
// Holds field widths, the controller state type and the command/status
// structs passed between controller and datapath. No dependencies.
package ljfs_pkg;

   localparam int IN_TIME_W   = 16;
   localparam int JOB_IDX_W   = 4;
   localparam int RES_TIME_W  = 21;
   localparam int SUM_W       = 25;
   localparam int REQ_DATA_W  = 2 * IN_TIME_W;
   localparam int RSP_USED_W  = JOB_IDX_W + 4 * RES_TIME_W + 2 * SUM_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SELECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;          // store the accepted job
      logic batch_start;   // last job accepted: begin scheduling
      logic scan_go;       // keep the store scan running
      logic select;        // choose the next job from the scan results
      logic emit;          // write the result into the output register
      logic batch_clear;   // final result written: empty the batch
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
      logic last_job;
   } status_type;

endpackage

/* hw/rtl/ljfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the job store. No dependencies.
module ljfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ljfs_ctrl.sv */
// Controller state machine of the scheduler: loading, scan, select, emit.
// Depends on ljfs_pkg for the state type and the command/status structs.
module ljfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   input  ljfs_pkg::status_type   status,
   output ljfs_pkg::cmd_type      cmd
);
   import ljfs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_job ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready      = 1'b1;
            cmd.load        = req_tvalid;
            cmd.batch_start = req_tvalid && req_tlast;
         end
         ST_SCAN: begin
            cmd.scan_go = 1'b1;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit        = status.out_free;
            cmd.batch_clear = status.out_free && status.last_job;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hw/rtl/ljfs_datapath.sv */
// Datapath of the scheduler: job store, scan trackers, selection arithmetic,
// running sums and the result register. Depends on ljfs_pkg and ljfs_ram.
module ljfs_datapath #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ljfs_pkg::cmd_type                  cmd,
   output ljfs_pkg::status_type               status,
   input  logic [ljfs_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ljfs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import ljfs_pkg::*;

   localparam int TW     = TIME_BITS;
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CT_W   = TIME_BITS + CNT_W;
   localparam int PAD_W  = RSP_DATA_W - RSP_USED_W;

   // batch control
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic                 first_ff, first_in;
   logic [CT_W-1:0]      ct_ff, ct_in;

   // scan
   logic [CNT_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 issue, scan_init, wr_en, pend;
   logic [2*TW-1:0]      rd_data;
   logic [TW-1:0]        rd_arr, rd_burst;

   // earliest arrival (first index) and longest burst within that arrival group
   logic                 e_vld_ff;
   logic [TW-1:0]        e_arr_ff, e_burst_ff, g_burst_ff;
   logic [IDX_W-1:0]     e_idx_ff, g_idx_ff;
   // longest burst among jobs already arrived
   logic                 l_vld_ff;
   logic [TW-1:0]        l_arr_ff, l_burst_ff;
   logic [IDX_W-1:0]     l_idx_ff;

   // selection stage
   logic [IDX_W-1:0]     sel_idx;
   logic [TW-1:0]        sel_arr, sel_burst;
   logic [CT_W-1:0]      sel_start;
   logic [IDX_W-1:0]     sel_idx_ff;
   logic [TW-1:0]        burst_ff;
   logic [CT_W-1:0]      start_ff, wait_ff, comp_ff;
   logic [CT_W-1:0]      tat;

   // sums and result register
   logic [SUM_W-1:0]      wsum_ff, wsum_in, tsum_ff, tsum_in;
   logic                  out_vld_ff;
   logic [JOB_IDX_W-1:0]  o_idx_ff;
   logic [RES_TIME_W-1:0] o_start_ff, o_wait_ff, o_comp_ff, o_tat_ff;
   logic [SUM_W-1:0]      o_tw_ff, o_tt_ff;
   logic                  o_last_ff;

   assign wr_en     = cmd.load && (count_ff < CNT_W'(MAX_PROCS));
   assign issue     = cmd.scan_go && (scan_addr_ff != count_ff);
   assign scan_init = cmd.batch_start || (cmd.emit && !status.last_job);

   ljfs_ram #(
      .WIDTH (2 * TW),
      .DEPTH (MAX_PROCS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({TW'(req_tdata[2*IN_TIME_W-1:IN_TIME_W]), TW'(req_tdata[IN_TIME_W-1:0])}),
      .rd_addr (scan_addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_arr   = rd_data[TW-1:0];
   assign rd_burst = rd_data[2*TW-1:TW];
   assign pend     = rd_vld_ff && !done_ff[rd_idx_ff];

   assign status.scan_done = (scan_addr_ff == count_ff) && !rd_vld_ff;
   assign status.out_free  = !out_vld_ff || rsp_tready;
   assign status.last_job  = ((emit_cnt_ff + CNT_W'(1)) == count_ff);

   // batch control next state
   always_comb begin
      count_in    = count_ff;
      emit_cnt_in = emit_cnt_ff;
      done_in     = done_ff;
      first_in    = first_ff;
      ct_in       = ct_ff;
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.batch_clear) begin
         count_in = '0;
      end
      if (cmd.batch_start || cmd.batch_clear) begin
         done_in     = '0;
         emit_cnt_in = '0;
         first_in    = cmd.batch_start;
      end
      if (cmd.select) begin
         done_in[sel_idx] = 1'b1;
         first_in         = 1'b0;
         ct_in            = sel_start + CT_W'(sel_burst);
      end
      if (cmd.emit) begin
         emit_cnt_in = emit_cnt_ff + CNT_W'(1);
      end
      if (cmd.batch_clear) begin
         emit_cnt_in = '0;
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (scan_init) begin
         scan_addr_in = '0;
      end else if (issue) begin
         scan_addr_in = scan_addr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         emit_cnt_ff  <= '0;
         done_ff      <= '0;
         first_ff     <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         e_vld_ff     <= 1'b0;
         l_vld_ff     <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         emit_cnt_ff  <= emit_cnt_in;
         done_ff      <= done_in;
         first_ff     <= first_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= issue;
         if (scan_init) begin
            e_vld_ff <= 1'b0;
            l_vld_ff <= 1'b0;
         end else begin
            if (pend) begin
               e_vld_ff <= 1'b1;
            end
            if (pend && (CT_W'(rd_arr) <= ct_ff)) begin
               l_vld_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // scan trackers and payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[IDX_W-1:0];
      ct_ff     <= ct_in;
      if (!scan_init && pend) begin
         if (!e_vld_ff || (rd_arr < e_arr_ff)) begin
            e_arr_ff   <= rd_arr;
            e_burst_ff <= rd_burst;
            e_idx_ff   <= rd_idx_ff;
            g_burst_ff <= rd_burst;
            g_idx_ff   <= rd_idx_ff;
         end else if ((rd_arr == e_arr_ff) && (rd_burst > g_burst_ff)) begin
            g_burst_ff <= rd_burst;
            g_idx_ff   <= rd_idx_ff;
         end
         if ((CT_W'(rd_arr) <= ct_ff) && (!l_vld_ff || (rd_burst > l_burst_ff))) begin
            l_arr_ff   <= rd_arr;
            l_burst_ff <= rd_burst;
            l_idx_ff   <= rd_idx_ff;
         end
      end
      if (cmd.select) begin
         sel_idx_ff <= sel_idx;
         burst_ff   <= sel_burst;
         start_ff   <= sel_start;
         wait_ff    <= sel_start - CT_W'(sel_arr);
         comp_ff    <= sel_start + CT_W'(sel_burst);
      end
      if (cmd.batch_start) begin
         wsum_ff <= '0;
         tsum_ff <= '0;
      end else if (cmd.emit) begin
         wsum_ff <= wsum_in;
         tsum_ff <= tsum_in;
      end
      if (cmd.emit) begin
         o_idx_ff   <= JOB_IDX_W'(sel_idx_ff);
         o_start_ff <= RES_TIME_W'(start_ff);
         o_wait_ff  <= RES_TIME_W'(wait_ff);
         o_comp_ff  <= RES_TIME_W'(comp_ff);
         o_tat_ff   <= RES_TIME_W'(tat);
         o_tw_ff    <= wsum_in;
         o_tt_ff    <= tsum_in;
         o_last_ff  <= status.last_job;
      end
   end

   // First job runs at the earliest arrival; later on, when nothing has
   // arrived, the clock jumps to the earliest pending arrival.
   always_comb begin
      if (first_ff) begin
         sel_idx   = e_idx_ff;
         sel_arr   = e_arr_ff;
         sel_burst = e_burst_ff;
         sel_start = CT_W'(e_arr_ff);
      end else if (l_vld_ff) begin
         sel_idx   = l_idx_ff;
         sel_arr   = l_arr_ff;
         sel_burst = l_burst_ff;
         sel_start = ct_ff;
      end else begin
         sel_idx   = g_idx_ff;
         sel_arr   = e_arr_ff;
         sel_burst = g_burst_ff;
         sel_start = CT_W'(e_arr_ff);
      end
   end

   assign tat     = wait_ff + CT_W'(burst_ff);
   assign wsum_in = wsum_ff + SUM_W'(wait_ff);
   assign tsum_in = tsum_ff + SUM_W'(wait_ff) + SUM_W'(burst_ff);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_tt_ff, o_tw_ff, o_tat_ff, o_comp_ff,
                        o_wait_ff, o_start_ff, o_idx_ff};

   a_select_has_job: assert property (@(posedge clock) disable iff (reset)
      cmd.select |-> e_vld_ff)
      else $error("select without a pending job");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_vld_ff || rsp_tready))
      else $error("result register overwritten");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) <= int'(count_ff))
      else $error("more jobs marked done than stored");

endmodule

/* hw/rtl/longest_job_first_scheduler.sv */
// Non-preemptive longest-job-first scheduler, top level.
// Depends on ljfs_pkg, ljfs_ctrl, ljfs_datapath (and ljfs_ram beneath it).
//
// Usage:
//   req channel: one item per job, tdata = {burst, arrival}; tlast marks the
//   final job of a batch and starts scheduling. Jobs beyond MAX_PROCS are
//   dropped, but their tlast still starts the schedule.
//   rsp channel: one item per job run, in run order; tlast on the last one.
//   Loading accepts one item per cycle. After the batch's last item, each job
//   scheduled costs one scan of the job store (N reads, then the read data
//   drains), a select step and an emit step. The single read port of the
//   job store limits how fast results come.
//   req_tready is low while a batch is being scheduled.
//   Results wait in an output register; when the receiver stalls, scheduling
//   holds before writing the next result, and the final result may still be
//   waiting while the next batch loads.
//   Reset (synchronous) empties the batch and drops any pending result.
module longest_job_first_scheduler #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] arrival_time, [31:16] burst_time
   input  logic [ljfs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] job_index, [24:4] start_time, [45:25] waiting_time,
   // [66:46] completion_time, [87:67] turnaround_time,
   // [112:88] total_waiting, [137:113] total_turnaround, [143:138] zero
   output logic [ljfs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import ljfs_pkg::*;

   cmd_type    cmd;
   status_type status;

   ljfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ljfs_datapath #(
      .MAX_PROCS (MAX_PROCS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/tb_longest_job_first_scheduler.sv */
// Self-checking bench for longest_job_first_scheduler: directed batches, then random
// batches under sender idling and receiver stalls. Results are scored against a
// schedule model or typed-in values. Depends on ljfs_pkg and the scheduler RTL.
module tb_longest_job_first_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import ljfs_pkg::*;

   localparam int MAX_JOBS  = 16;
   localparam int TAIL_WAIT = 400;

   typedef struct packed {
      logic                  last;
      logic [SUM_W-1:0]      tot_tat;
      logic [SUM_W-1:0]      tot_wait;
      logic [RES_TIME_W-1:0] tat;
      logic [RES_TIME_W-1:0] comp;
      logic [RES_TIME_W-1:0] wait_t;
      logic [RES_TIME_W-1:0] start;
      logic [JOB_IDX_W-1:0]  idx;
   } job_run_t;

   typedef struct {
      logic [IN_TIME_W-1:0] arr;
      logic [IN_TIME_W-1:0] bst;
      bit                   last;
      bit                   typed;
      job_run_t             res;
   } job_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // travels alongside the request item: typed-in expectation for directed rows
   bit       cur_typed;
   job_run_t cur_res;

   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int run_errors = 0;

   job_run_t expected_runs[$];
   job_row_t directed_rows[$];

   // model state
   logic [IN_TIME_W-1:0] arr_store[MAX_JOBS];
   logic [IN_TIME_W-1:0] bst_store[MAX_JOBS];
   bit                   done_mark[MAX_JOBS];
   int                   job_count = 0;
   logic [31:0]          now_tick;

   always #2 clock = ~clock;

   longest_job_first_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic int earliest_pending();
      int best;
      best = -1;
      for (int i = 0; i < job_count; i++) begin
         if (done_mark[i]) continue;
         if (best < 0 || arr_store[i] < arr_store[best]) best = i;
      end
      return best;
   endfunction

   function automatic int longest_arrived();
      int best;
      best = -1;
      for (int i = 0; i < job_count; i++) begin
         if (done_mark[i] || 32'(arr_store[i]) > now_tick) continue;
         if (best < 0 || bst_store[i] > bst_store[best]) best = i;
      end
      return best;
   endfunction

   // Stores a job if room is left; on the last item works out the whole run order.
   task automatic schedule_job(input logic [IN_TIME_W-1:0] arr, input logic [IN_TIME_W-1:0] bst,
                               input bit last, input bit typed, input job_run_t typed_res);
      int          j;
      logic [31:0] wait_v, tat_v, wsum, tsum;
      job_run_t    r;
      if (job_count < MAX_JOBS) begin
         arr_store[job_count] = arr;
         bst_store[job_count] = bst;
         job_count++;
      end
      if (!last) return;
      foreach (done_mark[i]) done_mark[i] = 1'b0;
      now_tick = 0;
      wsum = 0;
      tsum = 0;
      for (int k = 0; k < job_count; k++) begin
         if (k == 0) begin
            j = earliest_pending();
            now_tick = 32'(arr_store[j]);
         end else begin
            j = longest_arrived();
            if (j < 0) begin
               // idle gap: jump to the next arrival
               now_tick = 32'(arr_store[earliest_pending()]);
               j = longest_arrived();
            end
         end
         wait_v = now_tick - 32'(arr_store[j]);
         tat_v = wait_v + 32'(bst_store[j]);
         r.idx = j[JOB_IDX_W-1:0];
         r.start = now_tick[RES_TIME_W-1:0];
         r.wait_t = wait_v[RES_TIME_W-1:0];
         now_tick = now_tick + 32'(bst_store[j]);
         r.comp = now_tick[RES_TIME_W-1:0];
         r.tat = tat_v[RES_TIME_W-1:0];
         wsum = wsum + wait_v;
         tsum = tsum + tat_v;
         r.tot_wait = wsum[SUM_W-1:0];
         r.tot_tat = tsum[SUM_W-1:0];
         r.last = (k + 1 == job_count);
         done_mark[j] = 1'b1;
         if (!typed) expected_runs.push_back(r);
      end
      if (typed) expected_runs.push_back(typed_res);
      job_count = 0;
   endtask

   always @(posedge clock) begin : score
      job_run_t got, want;
      rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
      if (!reset) begin
         if (req_tvalid && req_tready)
            schedule_job(req_tdata[IN_TIME_W-1:0], req_tdata[2*IN_TIME_W-1:IN_TIME_W],
                         req_tlast, cur_typed, cur_res);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata[RSP_USED_W-1:0]};
            if (expected_runs.size() == 0) begin
               run_errors++;
               if (run_errors <= 10)
                  $display("%0t unexpected result item: idx %0d start %0d", $realtime,
                           got.idx, got.start);
            end else begin
               want = expected_runs.pop_front();
               if (got.idx != want.idx || got.start != want.start ||
                   got.wait_t != want.wait_t || got.comp != want.comp ||
                   got.tat != want.tat || got.tot_wait != want.tot_wait ||
                   got.tot_tat != want.tot_tat || got.last != want.last) begin
                  run_errors++;
                  if (run_errors <= 10)
                     $display({"%0t mismatch exp idx %0d st %0d wt %0d ct %0d tat %0d",
                               " tw %0d tt %0d last %0b / got idx %0d st %0d wt %0d ct %0d",
                               " tat %0d tw %0d tt %0d last %0b"}, $realtime,
                              want.idx, want.start, want.wait_t, want.comp, want.tat,
                              want.tot_wait, want.tot_tat, want.last,
                              got.idx, got.start, got.wait_t, got.comp, got.tat,
                              got.tot_wait, got.tot_tat, got.last);
               end
            end
         end
      end
   end

   task automatic send_item(input logic [IN_TIME_W-1:0] arr, input logic [IN_TIME_W-1:0] bst,
                            input bit last, input bit typed, input job_run_t res);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bst, arr};
      req_tlast <= last;
      cur_typed <= typed;
      cur_res <= res;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic void add_row(input logic [IN_TIME_W-1:0] arr,
                                   input logic [IN_TIME_W-1:0] bst, input bit last,
                                   input bit typed, input job_run_t res);
      job_row_t row;
      row.arr = arr;
      row.bst = bst;
      row.last = last;
      row.typed = typed;
      row.res = res;
      directed_rows.push_back(row);
   endfunction

   // One random batch; some run past capacity so the extra jobs get dropped.
   task automatic random_batch(output int sent);
      int n, amode, bmode, sel;
      logic [IN_TIME_W-1:0] a, b, base;
      sel = $urandom_range(99);
      if (sel < 70) n = $urandom_range(1, 6);
      else if (sel < 90) n = $urandom_range(7, 16);
      else n = $urandom_range(17, 20);
      amode = $urandom_range(4);
      bmode = $urandom_range(3);
      base = 16'($urandom);
      for (int k = 0; k < n; k++) begin
         case (amode)
            0: a = 16'($urandom_range(30));
            1: a = 16'($urandom);
            2: a = 16'(k * $urandom_range(0, 4000));   // spread out: idle gaps
            3: a = base;
            default: a = 16'hFFFF - 16'($urandom_range(20));
         endcase
         case (bmode)
            0: b = 16'($urandom_range(20));
            1: b = 16'($urandom);
            2: begin
               sel = $urandom_range(2);
               b = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'hFFFE : 16'h0000;
            end
            default: b = 16'($urandom_range(1, 8));
         endcase
         send_item(a, b, k == n - 1, 1'b0, '0);
      end
      sent = n;
   endtask

   initial begin
      int left, sent;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      cur_typed <= 1'b0;
      cur_res <= '0;

      // single job batches at the extremes
      add_row(16'h0000, 16'h0000, 1'b1, 1'b1,
              '{last: 1'b1, tot_tat: 0, tot_wait: 0, tat: 0, comp: 0, wait_t: 0,
                start: 0, idx: 0});
      add_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
              '{last: 1'b1, tot_tat: 65535, tot_wait: 0, tat: 65535, comp: 131070,
                wait_t: 0, start: 65535, idx: 0});
      // idle gap after the first two jobs
      add_row(16'd0, 16'd5, 1'b0, 1'b0, '0);
      add_row(16'd100, 16'd3, 1'b0, 1'b0, '0);
      add_row(16'd2, 16'd10, 1'b1, 1'b0, '0);
      // equal jobs: ties go to the lowest index
      add_row(16'd7, 16'd4, 1'b0, 1'b0, '0);
      add_row(16'd7, 16'd4, 1'b0, 1'b0, '0);
      add_row(16'd7, 16'd4, 1'b1, 1'b0, '0);
      // full batch, then a dropped job whose tlast still starts the schedule
      for (int i = 0; i < MAX_JOBS; i++)
         add_row((i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'hFFFF : 16'(i * 1000),
                 i[0] ? 16'hFFFF : 16'(i), 1'b0, 1'b0, '0);
      add_row(16'd1234, 16'd4321, 1'b1, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].arr, directed_rows[i].bst, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].res);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
            default: begin src_idle_pct = 35; snk_stall_pct = 35; end
         endcase
         left = 119;
         while (left > 0) begin
            random_batch(sent);
            left -= sent;
         end
      end
      req_tvalid <= 1'b0;
      // let the scoreboard take the final item before looking at the queue
      @(posedge clock);

      while (expected_runs.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (run_errors == 0 && expected_runs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
